// File: rtl/mmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Masked mixed-radix encoder package
// Shared constants and word types for the encoder chain and its top level.
// ----------------------------------------------------------------------------
package mmr_pkg;

    localparam int FEATURES   = 4;
    localparam int VALUE_BITS = 4;
    localparam int JOINED     = 2 * FEATURES;
    localparam int VALS_W     = JOINED * VALUE_BITS;
    localparam int STATE_W    = FEATURES * VALUE_BITS;
    localparam int INDEX_W    = 32;

    typedef struct packed {
        logic [15:0] current_values;
        logic [3:0]  current_defined;
        logic [15:0] next_values;
        logic [3:0]  next_defined;
        logic [7:0]  parent_mask;
    } t_in_word;

    typedef struct packed {
        logic [31:0] flat_index;
        logic        undefined_parent;
    } t_out_word;

    typedef struct packed {
        logic [VALS_W-1:0]  vals;
        logic [JOINED-1:0]  defs;
        logic [JOINED-1:0]  mask;
        logic [INDEX_W-1:0] index;
        logic [INDEX_W-1:0] weight;
        logic               err;
    } t_cell_word;

endpackage
`default_nettype wire

// File: rtl/masked_mixed_radix_encode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Masked mixed-radix encoder
// Joins a current and a next factored state and forms the mixed-radix flat
// index over the features selected by the parent mask.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_stall, i_word) takes one word per cycle while
// o_stall is low; the output channel (o_valid, i_stall, o_word) gives one
// result word per input word, in order. The word passes a chain of eight
// cells, one per joined feature, highest feature first, and each cell registers it.
// Throughput is one word per cycle while i_stall is low, set by the cell chain.
// When the receiver stalls, the result is held and each cell holds its word
// only if the cell after it is full, so gaps close up; o_stall rises only
// once the whole chain is full. The feature sizes come from the register
// written through i_cfg_we and i_cfg_wdata; it must be written while the
// block is idle. Reset empties the chain and sets every size to sixteen.
// ----------------------------------------------------------------------------
module masked_mixed_radix_encode
    import mmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_word    i_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_word        o_word
);

    logic [STATE_W-1:0] r_sizes;
    t_cell_word         w_head;
    t_cell_word         w_word  [JOINED+1];
    logic               w_valid [JOINED+1];
    logic               w_stall [JOINED+1];
    logic [JOINED-1:0]  w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sizes <= '1;
        end else if (i_cfg_we) begin
            r_sizes <= i_cfg_wdata[STATE_W-1:0];
        end
    end

    always_comb begin
        w_head        = '0;
        w_head.vals   = {i_word.next_values, i_word.current_values};
        w_head.defs   = {i_word.next_defined, i_word.current_defined};
        w_head.mask   = i_word.parent_mask;
        w_head.weight = INDEX_W'(1);
    end

    assign w_word[0]       = w_head;
    assign w_valid[0]      = i_valid;
    assign o_stall         = w_stall[0];
    assign w_stall[JOINED] = i_stall;

    for (genvar j = 0; j < JOINED; j++) begin : g_cell
        localparam int Pos = JOINED - 1 - j;
        localparam int Feat = Pos % FEATURES;

        mmr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_size_m1 (r_sizes[Feat*VALUE_BITS +: VALUE_BITS]),
            .i_valid   (w_valid[j]),
            .o_stall   (w_stall[j]),
            .i_word    (w_word[j]),
            .o_valid   (w_valid[j+1]),
            .i_stall   (w_stall[j+1]),
            .o_word    (w_word[j+1])
        );

        assign w_full[j] = w_valid[j+1];
    end

    assign o_valid                = w_valid[JOINED];
    assign o_word.undefined_parent = w_word[JOINED].err;
    assign o_word.flat_index      = w_word[JOINED].err ? '0 : w_word[JOINED].index;

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&w_full))
        else $error("input stalled while the chain has a free cell");

    a_accept_enters_chain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_valid[1])
        else $error("accepted word did not enter the first cell");

    a_error_zero_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.undefined_parent) |-> (o_word.flat_index == '0))
        else $error("error result carries a nonzero index");

endmodule
`default_nettype wire

// File: rtl/mmr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Masked mixed-radix encoder cell
// Folds the highest remaining joined feature, if selected, into the running
// index and weight (err if undefined), then shifts the feature vectors up for the next cell.
// ----------------------------------------------------------------------------
module mmr_cell
    import mmr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [VALUE_BITS-1:0] i_size_m1,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_cell_word            i_word,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_cell_word                 o_word
);

    logic                  r_valid;
    t_cell_word            r_word;
    t_cell_word            n_word;
    logic [VALUE_BITS-1:0] w_val;
    logic                  w_def;
    logic                  w_sel;
    logic [VALUE_BITS:0]   w_size;

    assign w_val  = i_word.vals[VALS_W-1 -: VALUE_BITS];
    assign w_def  = i_word.defs[JOINED-1];
    assign w_sel  = i_word.mask[JOINED-1];
    assign w_size = {1'b0, i_size_m1} + {{VALUE_BITS{1'b0}}, 1'b1};

    always_comb begin
        n_word      = i_word;
        n_word.vals = i_word.vals << VALUE_BITS;
        n_word.defs = i_word.defs << 1;
        n_word.mask = i_word.mask << 1;
        if (w_sel && !w_def) begin
            n_word.err = 1'b1;
        end else if (w_sel) begin
            n_word.index  = i_word.index
                + INDEX_W'({{(INDEX_W-VALUE_BITS){1'b0}}, w_val} * i_word.weight);
            n_word.weight = INDEX_W'(i_word.weight
                * {{(INDEX_W-VALUE_BITS-1){1'b0}}, w_size});
        end
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule
`default_nettype wire

// File: verif/masked_mixed_radix_encode_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Masked mixed-radix encoder testbench
// A clocked driver sends input words from a queue in random bursts while the
// receiver stalls on a changing pattern. Each accepted word is run through a
// local predictor of the flat index and the undefined-parent flag, and a
// clocked monitor checks every result word against the oldest prediction.
// The size register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module masked_mixed_radix_encode_test;
    import mmr_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'h0000;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_in_word    i_word      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_out_word   o_word;

    t_in_word    pending_words[$];
    t_out_word   expected_results[$];
    logic [15:0] sizes_copy = 16'hFFFF;
    int          n_outstanding = 0;
    int          n_errors = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_seg_left = 0;
    int          stall_phase = 0;

    masked_mixed_radix_encode dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_out_word predict_flat_index(t_in_word w, logic [15:0] sizes);
        t_out_word   r;
        logic [31:0] index;
        logic [31:0] weight;
        logic        err;
        logic        sel;
        logic        def;
        logic [3:0]  val;
        int          k;
        index  = 32'd0;
        weight = 32'd1;
        err    = 1'b0;
        for (int pos = JOINED - 1; pos >= 0; pos--) begin
            k   = pos % FEATURES;
            sel = w.parent_mask[pos];
            if (pos >= FEATURES) begin
                def = w.next_defined[k];
                val = w.next_values[k*VALUE_BITS +: VALUE_BITS];
            end else begin
                def = w.current_defined[k];
                val = w.current_values[k*VALUE_BITS +: VALUE_BITS];
            end
            if (sel) begin
                if (!def) begin
                    err = 1'b1;
                end else begin
                    index  = index + 32'(val) * weight;
                    weight = weight * (32'(sizes[k*VALUE_BITS +: VALUE_BITS]) + 32'd1);
                end
            end
        end
        r.flat_index       = err ? 32'd0 : index;
        r.undefined_parent = err;
        return r;
    endfunction

    function automatic t_in_word make_word(logic [15:0] cv, logic [3:0] cd, logic [15:0] nv,
                                           logic [3:0] nd, logic [7:0] m);
        t_in_word w;
        w.current_values  = cv;
        w.current_defined = cd;
        w.next_values     = nv;
        w.next_defined    = nd;
        w.parent_mask     = m;
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        n_errors++;
    endtask

    task automatic queue_word(t_in_word w);
        n_outstanding++;
        pending_words = {pending_words, w};
    endtask

    // Waits until every queued word has produced its result, then lets the
    // pipeline settle for longer than its latency.
    task automatic wait_idle();
        while (n_outstanding != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_sizes(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sizes_copy  = v;
    endtask

    task automatic queue_random(int count);
        t_in_word   w;
        logic [3:0] lim;
        for (int i = 0; i < count; i++) begin
            w.current_values = 16'($urandom);
            w.next_values    = 16'($urandom);
            // Keep values inside their sizes for a share of the words.
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < FEATURES; k++) begin
                    lim = sizes_copy[k*VALUE_BITS +: VALUE_BITS];
                    w.current_values[k*VALUE_BITS +: VALUE_BITS] = 4'($urandom_range(0, lim));
                    w.next_values[k*VALUE_BITS +: VALUE_BITS]    = 4'($urandom_range(0, lim));
                end
            end
            case ($urandom_range(0, 9))
                0:       w.parent_mask = 8'h00;
                1:       w.parent_mask = 8'hFF;
                default: w.parent_mask = 8'($urandom);
            endcase
            w.current_defined = 4'($urandom);
            w.next_defined    = 4'($urandom);
            // Most words have every selected feature defined.
            if ($urandom_range(0, 9) < 7) begin
                w.current_defined = w.current_defined | w.parent_mask[3:0];
                w.next_defined    = w.next_defined | w.parent_mask[7:4];
            end
            queue_word(w);
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic     nv;
        t_in_word nw;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            nw = i_word;
            if (i_valid && !o_stall) begin
                expected_results = {expected_results, predict_flat_index(i_word, sizes_copy)};
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0) begin
                    nw = pending_words.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_valid <= nv;
            i_word  <= nw;
        end
    end

    always @(posedge i_clk) begin : monitor
        logic      ns;
        t_out_word exp_word;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %h flag %b",
                                          o_word.flat_index, o_word.undefined_parent));
            end else begin
                exp_word = expected_results.pop_front();
                n_outstanding--;
                if (o_word.flat_index !== exp_word.flat_index)
                    report_mismatch($sformatf("flat_index got %h want %h",
                                              o_word.flat_index, exp_word.flat_index));
                if (o_word.undefined_parent !== exp_word.undefined_parent)
                    report_mismatch($sformatf("undefined_parent got %b want %b",
                                              o_word.undefined_parent,
                                              exp_word.undefined_parent));
            end
        end
        if (stall_seg_left == 0) begin
            stall_seg_left = $urandom_range(20, 200);
            stall_mode     = $urandom_range(0, 3);
        end else begin
            stall_seg_left--;
        end
        stall_phase++;
        case (stall_mode)
            0:       ns = 1'b0;
            1:       ns = ($urandom_range(0, 3) == 0);
            2:       ns = ($urandom_range(0, 3) != 0);
            default: ns = ((stall_phase % 7) < 3);
        endcase
        i_stall <= ns;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] phase_sizes[7];
        phase_sizes[0] = 16'hFFFF;
        phase_sizes[1] = 16'h3210;
        phase_sizes[2] = 16'($urandom);
        phase_sizes[3] = 16'($urandom);
        phase_sizes[4] = 16'h0F0F;
        phase_sizes[5] = 16'($urandom);
        phase_sizes[6] = 16'h7777;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        write_sizes(16'hFFFF);
        queue_word(make_word(16'hFFFF, 4'hF, 16'hFFFF, 4'hF, 8'h00));
        queue_word(make_word(16'h0000, 4'hF, 16'h0000, 4'hF, 8'hFF));
        queue_word(make_word(16'hFFFF, 4'hF, 16'hFFFF, 4'hF, 8'hFF));
        queue_word(make_word(16'h1234, 4'h0, 16'h5678, 4'hF, 8'hFF));
        queue_word(make_word(16'h0005, 4'h1, 16'h0000, 4'h0, 8'h01));
        queue_word(make_word(16'h0000, 4'h0, 16'hA000, 4'h8, 8'h80));
        queue_word(make_word(16'h9ABC, 4'hF, 16'hDEF0, 4'h0, 8'h0F));
        queue_word(make_word(16'h9ABC, 4'hF, 16'hDEF0, 4'hE, 8'hFF));
        queue_word(make_word(16'h0000, 4'h0, 16'h0000, 4'h0, 8'h00));
        queue_word(make_word(16'hA5A5, 4'hF, 16'h5A5A, 4'hF, 8'hAA));
        queue_word(make_word(16'hA5A5, 4'hF, 16'h5A5A, 4'hF, 8'h55));
        queue_word(make_word(16'h0000, 4'h0, 16'hFFFF, 4'hF, 8'hF0));
        wait_idle();

        write_sizes(16'h0000);
        queue_word(make_word(16'hFFFF, 4'hF, 16'hFFFF, 4'hF, 8'hFF));
        queue_word(make_word(16'h00F0, 4'h2, 16'h000F, 4'h1, 8'h12));
        queue_word(make_word(16'hFFFF, 4'hF, 16'hFFFF, 4'h7, 8'h7F));
        queue_word(make_word(16'hFFFF, 4'hF, 16'hFFFF, 4'h7, 8'h80));
        queue_random(80);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            write_sizes(phase_sizes[p]);
            queue_random(80);
            wait_idle();
        end

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
